[sv/tone_pattern_sequencer_macros.svh]
// assertion macros for the tone pattern sequencer
// no dependencies; included by the rtl files that carry assertions
`ifndef TONE_PATTERN_SEQUENCER_MACROS_SVH
`define TONE_PATTERN_SEQUENCER_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define TPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define TPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define TPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[sv/tps_pkg.sv]
// shared types and codes for the tone pattern sequencer
// no dependencies
`default_nettype none
package tps_pkg;

   // default sizes
   localparam int DEF_MAX_STEPS     = 16;
   localparam int DEF_DURATION_BITS = 16;

   // field widths fixed by the interface
   localparam int OP_BITS    = 2;
   localparam int ADDR_W     = 4;
   localparam int TICKS_W    = 16;
   localparam int STEP_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_START = 2'd1;
   localparam logic [OP_BITS-1:0] OP_STOP  = 2'd2;
   localparam logic [OP_BITS-1:0] OP_WRITE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_MODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DELAY = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic [ADDR_W-1:0]  step_addr;
      logic [TICKS_W-1:0] step_ticks;
      logic               step_sound;
   } req_type;

   typedef struct packed {
      logic              pin_level;
      logic              busy_res;
      logic [STEP_W-1:0] current_step;
      logic              finished;
   } rsp_type;

endpackage
`default_nettype wire

[sv/tps_step_store.sv]
// step table storage with a registered read of the coming step and a copy of entry zero
// depends on nothing but its parameters
`default_nettype none
module tps_step_store #(
   parameter int MAX_STEPS     = 16,
   parameter int DURATION_BITS = 16,
   localparam int ADDR_BITS    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_BITS-1:0]     wr_addr,
   input  logic [DURATION_BITS-1:0] wr_ticks,
   input  logic                     wr_sound,
   input  logic [ADDR_BITS-1:0]     rd_addr,
   output logic [DURATION_BITS-1:0] rd_ticks,
   output logic                     rd_sound,
   output logic [DURATION_BITS-1:0] zero_ticks,
   output logic                     zero_sound
);

   localparam int DEPTH = 2 ** ADDR_BITS;

   logic [DURATION_BITS:0] mem [DEPTH];
   logic [DURATION_BITS:0] rd_ff;
   logic [DURATION_BITS:0] zero_ff;
   logic [DURATION_BITS:0] wr_word;

   assign wr_word = {wr_ticks, wr_sound};

   // table write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
   end

   // registered read, a write to the same entry passes straight through
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= wr_word;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   // entry zero kept aside for the loop restart
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == '0)) begin
         zero_ff <= wr_word;
      end
   end

   assign rd_ticks   = rd_ff[DURATION_BITS:1];
   assign rd_sound   = rd_ff[0];
   assign zero_ticks = zero_ff[DURATION_BITS:1];
   assign zero_sound = zero_ff[0];

endmodule
`default_nettype wire

[sv/tone_pattern_sequencer.sv]
// top level of the tone pattern sequencer: command decode, step timer and result register
// depends on tps_pkg, tps_step_store and tone_pattern_sequencer_macros.svh
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    tps_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready    tps_pkg::rsp_type
//   csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// one item per cycle while req_ready is high; each item gives its result in the cycle after its transfer
// the timer compare and counter update sit between the step read register and the result register
// the step table read for the next expiry is prefetched, so an expiry never waits on the table
// reset is synchronous; the step table is not cleared and holds nothing until written
// req_ready drops only while a result waits and rsp_ready is low; csr_ready is always high
`default_nettype none
`include "tone_pattern_sequencer_macros.svh"
module tone_pattern_sequencer #(
   parameter int MAX_STEPS     = tps_pkg::DEF_MAX_STEPS,
   parameter int DURATION_BITS = tps_pkg::DEF_DURATION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tps_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tps_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tps_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tps_pkg::*;

   localparam int ADDR_BITS = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int IDX_BITS  = $clog2(MAX_STEPS + 1);
   localparam int CMP_BITS  = IDX_BITS + STEP_W;

   // configuration
   logic [STEP_W-1:0]        step_count_ff;
   logic                     loop_mode_ff;
   logic [TICKS_W-1:0]       start_delay_ff;

   // timer state
   logic [IDX_BITS-1:0]      idx_ff, idx_in;
   logic [DURATION_BITS-1:0] cnt_ff, cnt_in;
   logic [DURATION_BITS-1:0] limit_ff, limit_in;
   logic                     running_ff, running_in;
   logic                     pin_ff, pin_in;
   logic                     finished;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // table port
   logic                     wr_en;
   logic [ADDR_BITS-1:0]     wr_addr;
   logic [ADDR_BITS-1:0]     rd_addr;
   logic [DURATION_BITS-1:0] rd_ticks, zero_ticks;
   logic                     rd_sound, zero_sound;

   // width conversions
   logic [ADDR_BITS+ADDR_W-1:0]        addr_wide;
   logic [ADDR_BITS+IDX_BITS-1:0]      rd_wide;
   logic [DURATION_BITS+TICKS_W-1:0]   ticks_wide;
   logic [DURATION_BITS+TICKS_W-1:0]   delay_wide;
   logic [IDX_BITS+STEP_W-1:0]         step_wide;
   logic [CMP_BITS-1:0]                count_cmp, max_cmp, eff_cmp, idx_cmp;

   logic accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff  <= '0;
         loop_mode_ff   <= 1'b0;
         start_delay_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_COUNT:  step_count_ff  <= csr_wdata[STEP_W-1:0];
            CSR_LOOP_MODE:   loop_mode_ff   <= csr_wdata[0];
            CSR_START_DELAY: start_delay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // table write decode, entries beyond the table are dropped
   assign addr_wide  = {{ADDR_BITS{1'b0}}, req_data.step_addr};
   assign wr_addr    = addr_wide[ADDR_BITS-1:0];
   assign wr_en      = accept && (req_data.op == OP_WRITE)
                       && (addr_wide < (ADDR_BITS+ADDR_W)'(MAX_STEPS));
   assign ticks_wide = {{DURATION_BITS{1'b0}}, req_data.step_ticks};
   assign delay_wide = {{DURATION_BITS{1'b0}}, start_delay_ff};

   // effective step count, clipped to the table depth
   assign count_cmp = {{IDX_BITS{1'b0}}, step_count_ff};
   assign max_cmp   = CMP_BITS'(MAX_STEPS);
   assign eff_cmp   = (count_cmp > max_cmp) ? max_cmp : count_cmp;
   assign idx_cmp   = {{STEP_W{1'b0}}, idx_ff};

   // command decode and period timer
   always_comb begin
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      limit_in   = limit_ff;
      running_in = running_ff;
      pin_in     = pin_ff;
      finished   = 1'b0;
      if (accept) begin
         unique case (req_data.op)
            OP_TICK: begin
               if (running_ff) begin
                  if (cnt_ff == limit_ff) begin
                     cnt_in = '0;
                     if (idx_cmp < eff_cmp) begin
                        limit_in = rd_ticks;
                        pin_in   = rd_sound;
                        idx_in   = idx_ff + IDX_BITS'(1);
                     end else if (loop_mode_ff && (eff_cmp != '0)) begin
                        limit_in = zero_ticks;
                        pin_in   = zero_sound;
                        idx_in   = IDX_BITS'(1);
                     end else begin
                        running_in = 1'b0;
                        pin_in     = 1'b0;
                        finished   = 1'b1;
                     end
                  end else begin
                     cnt_in = cnt_ff + DURATION_BITS'(1);
                  end
               end
            end
            OP_START: begin
               idx_in     = '0;
               limit_in   = delay_wide[DURATION_BITS-1:0];
               cnt_in     = '0;
               running_in = 1'b1;
            end
            OP_STOP: begin
               pin_in     = 1'b0;
               running_in = 1'b0;
            end
            OP_WRITE: ;
            default: ;
         endcase
      end
   end

   // prefetch the entry the next expiry will load
   assign rd_wide = {{ADDR_BITS{1'b0}}, idx_in};
   assign rd_addr = rd_wide[ADDR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         cnt_ff     <= '0;
         limit_ff   <= '0;
         running_ff <= 1'b0;
         pin_ff     <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         cnt_ff     <= cnt_in;
         limit_ff   <= limit_in;
         running_ff <= running_in;
         pin_ff     <= pin_in;
      end
   end

   // result register
   assign step_wide = {{STEP_W{1'b0}}, idx_in};

   always_comb begin
      rsp_data_in.pin_level    = pin_in;
      rsp_data_in.busy_res     = running_in;
      rsp_data_in.current_step = step_wide[STEP_W-1:0];
      rsp_data_in.finished     = finished;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   tps_step_store #(
      .MAX_STEPS     (MAX_STEPS),
      .DURATION_BITS (DURATION_BITS)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_ticks   (ticks_wide[DURATION_BITS-1:0]),
      .wr_sound   (req_data.step_sound),
      .rd_addr    (rd_addr),
      .rd_ticks   (rd_ticks),
      .rd_sound   (rd_sound),
      .zero_ticks (zero_ticks),
      .zero_sound (zero_sound)
   );

   // checks on the timer and the result register
   `TPS_ASSERT_NOW(a_pin_needs_run, clock, reset, pin_ff, running_ff, "pin high while idle")
   `TPS_ASSERT_NOW(a_cnt_in_period, clock, reset, running_ff, cnt_ff <= limit_ff, "counter past period")
   `TPS_ASSERT_NOW(a_idx_in_range, clock, reset, 1'b1, idx_cmp <= max_cmp, "step index past table")
   `TPS_ASSERT_NOW(a_finish_quiet, clock, reset, rsp_valid_ff && rsp_data_ff.finished,
      !rsp_data_ff.busy_res && !rsp_data_ff.pin_level, "finished while busy or sounding")
   `TPS_ASSERT_NEXT(a_finish_stops, clock, reset, accept && finished, !running_ff && !pin_ff,
      "timer still running after finish")

endmodule
`default_nettype wire
